>>> rtl/core/braking_episode_monitor_assert.svh
// assertion macros for the braking episode monitor
`ifndef BRAKING_EPISODE_MONITOR_ASSERT_SVH
`define BRAKING_EPISODE_MONITOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BEM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bem check failed");
`define BEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bem check failed");
`else
`define BEM_ASSERT_SAME(label, ante, cons)
`define BEM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/bem_pkg.sv
package bem_pkg;

    typedef enum logic [2:0] {
        CFG_START_DECEL     = 3'd0,
        CFG_END_DECEL       = 3'd1,
        CFG_STOPPED_SPEED   = 3'd2,
        CFG_HARD_DECEL      = 3'd3,
        CFG_EMERGENCY_DECEL = 3'd4,
        CFG_COLLISION_DWELL = 3'd5,
        CFG_COLLISION_GAP   = 3'd6,
        CFG_TTC_LIMIT       = 3'd7
    } t_cfg_index;

    localparam int unsigned ACC_SCALE  = 1000;
    localparam int unsigned ACC_STEPS  = 26;
    localparam int unsigned TTC_STEPS  = 32;
    localparam int unsigned SQRT_STEPS = 32;

    localparam logic signed [15:0] RST_START_DECEL     = -16'sd128;
    localparam logic signed [15:0] RST_END_DECEL       = -16'sd51;
    localparam logic        [15:0] RST_STOPPED_SPEED   = 16'd26;
    localparam logic signed [15:0] RST_HARD_DECEL      = -16'sd1024;
    localparam logic signed [15:0] RST_EMERGENCY_DECEL = -16'sd1792;
    localparam logic        [19:0] RST_COLLISION_DWELL = 20'd10000;
    localparam logic        [23:0] RST_COLLISION_GAP   = 24'd256;
    localparam logic        [17:0] RST_TTC_LIMIT       = 18'd255744;

    typedef struct packed {
        logic       start;
        logic       sqrt;
        logic [5:0] steps;
    } t_eng_req;

endpackage

>>> rtl/core/bem_isu.sv
module bem_isu #(
    parameter int RW = 42
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bem_pkg::t_eng_req   i_req,
    input  logic [63:0]         i_num,
    input  logic [RW-1:0]       i_den,
    output logic                o_done,
    output logic [31:0]         o_q
);

    logic [RW-1:0] r_rem;
    logic [63:0]   r_num;
    logic [31:0]   r_q;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          r_sqrt;

    logic [RW-1:0] n_r2;
    logic [RW-1:0] n_trial;
    logic          n_ge;

    always_comb begin
        if (r_sqrt) begin
            n_r2    = {r_rem[RW-3:0], r_num[63:62]};
            n_trial = {{(RW-34){1'b0}}, r_q, 2'b01};
        end else begin
            n_r2    = {r_rem[RW-2:0], r_num[63]};
            n_trial = i_den;
        end
        n_ge = (n_r2 >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_sqrt <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.sqrt;
                r_cnt  <= i_req.steps;
                r_rem  <= '0;
                r_num  <= i_num;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? (n_r2 - n_trial) : n_r2;
                r_num <= r_sqrt ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
                r_q   <= {r_q[30:0], n_ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

>>> rtl/core/braking_episode_monitor.sv
// Braking episode monitor: one transfer on the input channel is one position update and
// gives exactly one result transfer. An update runs through the single shared restoring
// divide and square root unit, which runs 26 steps for acceleration, 32 for
// time-to-collision and 32 for the travelled distance, and through a shared 32x32
// multiplier used three times. The input is ready only between updates; configuration
// writes are always ready and belong between updates.
module braking_episode_monitor #(
    parameter int TIME_BITS = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [TIME_BITS-1:0]  i_time_ms,
    input  logic [15:0]           i_speed,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic [23:0]           i_gap,
    input  logic                  i_gap_valid,
    input  logic                  i_leader_cav_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [15:0]    o_acceleration,
    output logic [17:0]           o_ttc,
    output logic                  o_ttc_valid,
    output logic [31:0]           o_braking_distance,
    output logic                  o_hard_brake,
    output logic                  o_emergency_brake,
    output logic                  o_collision,
    output logic                  o_involves_cav,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data
);

    localparam int RW = ((TIME_BITS > 34) ? TIME_BITS : 34) + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_MULV, S_DIVA, S_DIVAW, S_DIVT, S_DIVTW,
        S_SQX, S_SQY, S_SQS, S_SQRT, S_SQRTW, S_FIN
    } t_state;

    t_state r_state;

    logic signed [15:0] r_start_decel, r_end_decel, r_hard_decel, r_emer_decel;
    logic [15:0]        r_stopped_speed;
    logic [19:0]        r_dwell;
    logic [23:0]        r_coll_gap;
    logic [17:0]        r_ttc_limit;

    logic                 r_have_prev, r_in_ep, r_hard_fired, r_emer_fired, r_stop_run;
    logic [15:0]          r_prev_spd;
    logic [TIME_BITS-1:0] r_prev_t, r_stopped_since;
    logic [31:0]          r_dist;
    logic signed [15:0]   r_peak;
    logic signed [31:0]   r_last_x, r_last_y;

    logic [TIME_BITS-1:0] r_t;
    logic [15:0]          r_spd;
    logic signed [31:0]   r_x, r_y;
    logic [23:0]          r_gap;
    logic                 r_gv, r_cav;

    logic [63:0] r_prod, r_sqx;
    logic [64:0] r_s;
    logic [25:0] r_accq;
    logic [31:0] r_ttc_raw;

    logic               r_out_valid;
    logic signed [15:0] r_out_acc;
    logic [17:0]        r_out_ttc;
    logic               r_out_ttc_ok, r_out_hard, r_out_emer, r_out_coll, r_out_cav;
    logic [31:0]        r_out_dist;

    bem_pkg::t_eng_req    n_req;
    logic [63:0]          n_num;
    logic [RW-1:0]        n_den;
    logic                 eng_done;
    logic [31:0]          eng_q;

    logic [31:0]          n_ma, n_mb;
    logic [63:0]          n_mp;
    logic                 n_dv_neg;
    logic [15:0]          n_dv_mag;
    logic [32:0]          n_dx, n_dy;
    logic [31:0]          n_ax, n_ay;
    logic [TIME_BITS-1:0] n_dt;

    logic                 n_acc_ok;
    logic signed [15:0]   n_acc;
    logic                 n_ttc_ok;
    logic                 n_stopped;
    logic                 n_in_ep, n_hard_fired, n_emer_fired, n_hard, n_emer;
    logic [31:0]          n_dist;
    logic signed [15:0]   n_peak;
    logic [32:0]          n_sum;
    logic                 n_stop_run, n_coll;
    logic [TIME_BITS-1:0] n_ss, n_el;

    always_comb begin
        n_dv_neg = (r_spd < r_prev_spd);
        n_dv_mag = n_dv_neg ? (r_prev_spd - r_spd) : (r_spd - r_prev_spd);
        n_dx = {r_x[31], r_x} - {r_last_x[31], r_last_x};
        n_dy = {r_y[31], r_y} - {r_last_y[31], r_last_y};
        n_ax = n_dx[32] ? 32'(-n_dx) : n_dx[31:0];
        n_ay = n_dy[32] ? 32'(-n_dy) : n_dy[31:0];
        n_dt = r_t - r_prev_t;

        case (r_state)
            S_MULV: begin
                n_ma = {16'd0, n_dv_mag};
                n_mb = 32'(bem_pkg::ACC_SCALE);
            end
            S_SQX: begin
                n_ma = n_ax;
                n_mb = n_ax;
            end
            default: begin
                n_ma = n_ay;
                n_mb = n_ay;
            end
        endcase
        n_mp = n_ma * n_mb;

        n_req = '0;
        n_num = '0;
        n_den = '0;
        case (r_state)
            S_DIVA, S_DIVAW: begin
                n_req.start = (r_state == S_DIVA);
                n_req.steps = 6'(bem_pkg::ACC_STEPS);
                n_num = {r_prod[25:0], 38'd0};
                n_den = {{(RW-TIME_BITS){1'b0}}, n_dt};
            end
            S_DIVT, S_DIVTW: begin
                n_req.start = (r_state == S_DIVT);
                n_req.steps = 6'(bem_pkg::TTC_STEPS);
                n_num = {r_gap, 8'd0, 32'd0};
                n_den = {{(RW-16){1'b0}}, r_spd};
            end
            S_SQRT: begin
                n_req.start = 1'b1;
                n_req.sqrt  = 1'b1;
                n_req.steps = 6'(bem_pkg::SQRT_STEPS);
                n_num = r_s[63:0];
            end
            default: begin
                n_num = r_s[63:0];
            end
        endcase
    end

    always_comb begin
        n_acc_ok = r_have_prev && (r_t > r_prev_t);
        if (!n_acc_ok) begin
            n_acc = '0;
        end else if (!n_dv_neg) begin
            n_acc = (r_accq[25:15] != '0) ? 16'sh7FFF : $signed(r_accq[15:0]);
        end else if (r_accq > 26'd32768) begin
            n_acc = -16'sh8000;
        end else begin
            n_acc = $signed(-r_accq[15:0]);
        end

        n_ttc_ok  = r_gv && (r_spd != 16'd0) && (r_ttc_raw < {14'd0, r_ttc_limit});
        n_stopped = (r_spd <= r_stopped_speed);

        n_in_ep      = r_in_ep;
        n_dist       = r_dist;
        n_peak       = r_peak;
        n_hard_fired = r_hard_fired;
        n_emer_fired = r_emer_fired;
        n_hard       = 1'b0;
        n_emer       = 1'b0;
        n_sum        = {1'b0, r_dist} + {1'b0, eng_q};
        if (!r_in_ep) begin
            if (n_acc <= r_start_decel && !n_stopped) begin
                n_in_ep      = 1'b1;
                n_dist       = '0;
                n_peak       = n_acc;
                n_hard_fired = 1'b0;
                n_emer_fired = 1'b0;
            end
        end else begin
            n_dist = (r_s[64] || n_sum[32]) ? 32'hFFFF_FFFF : n_sum[31:0];
            if (n_acc < r_peak) begin
                n_peak = n_acc;
            end
            if (!r_hard_fired && n_peak <= r_hard_decel) begin
                n_hard_fired = 1'b1;
                n_hard       = 1'b1;
            end
            if (!r_emer_fired && n_peak <= r_emer_decel) begin
                n_emer_fired = 1'b1;
                n_emer       = 1'b1;
            end
            if (n_stopped || n_acc >= r_end_decel) begin
                n_in_ep = 1'b0;
            end
        end

        n_stop_run = r_stop_run;
        n_ss       = r_stopped_since;
        n_coll     = 1'b0;
        if (n_stopped) begin
            if (!r_stop_run) begin
                n_stop_run = 1'b1;
                n_ss       = r_t;
            end
        end else begin
            n_stop_run = 1'b0;
            n_ss       = '0;
        end
        n_el = r_t - n_ss;
        if (n_stopped && r_t >= n_ss && n_el >= {{(TIME_BITS-20){1'b0}}, r_dwell}
                && r_gv && r_gap <= r_coll_gap) begin
            n_coll = 1'b1;
        end
    end

    bem_isu #(
        .RW (RW)
    ) u_isu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (eng_done),
        .o_q     (eng_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_start_decel   <= bem_pkg::RST_START_DECEL;
            r_end_decel     <= bem_pkg::RST_END_DECEL;
            r_stopped_speed <= bem_pkg::RST_STOPPED_SPEED;
            r_hard_decel    <= bem_pkg::RST_HARD_DECEL;
            r_emer_decel    <= bem_pkg::RST_EMERGENCY_DECEL;
            r_dwell         <= bem_pkg::RST_COLLISION_DWELL;
            r_coll_gap      <= bem_pkg::RST_COLLISION_GAP;
            r_ttc_limit     <= bem_pkg::RST_TTC_LIMIT;
            r_have_prev     <= 1'b0;
            r_prev_spd      <= '0;
            r_prev_t        <= '0;
            r_in_ep         <= 1'b0;
            r_dist          <= '0;
            r_peak          <= '0;
            r_last_x        <= '0;
            r_last_y        <= '0;
            r_hard_fired    <= 1'b0;
            r_emer_fired    <= 1'b0;
            r_stop_run      <= 1'b0;
            r_stopped_since <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (bem_pkg::t_cfg_index'(i_cfg_index))
                    bem_pkg::CFG_START_DECEL:     r_start_decel   <= i_cfg_data[15:0];
                    bem_pkg::CFG_END_DECEL:       r_end_decel     <= i_cfg_data[15:0];
                    bem_pkg::CFG_STOPPED_SPEED:   r_stopped_speed <= i_cfg_data[15:0];
                    bem_pkg::CFG_HARD_DECEL:      r_hard_decel    <= i_cfg_data[15:0];
                    bem_pkg::CFG_EMERGENCY_DECEL: r_emer_decel    <= i_cfg_data[15:0];
                    bem_pkg::CFG_COLLISION_DWELL: r_dwell         <= i_cfg_data[19:0];
                    bem_pkg::CFG_COLLISION_GAP:   r_coll_gap      <= i_cfg_data;
                    bem_pkg::CFG_TTC_LIMIT:       r_ttc_limit     <= i_cfg_data[17:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_t     <= i_time_ms;
                        r_spd   <= i_speed;
                        r_x     <= i_pos_x;
                        r_y     <= i_pos_y;
                        r_gap   <= i_gap;
                        r_gv    <= i_gap_valid;
                        r_cav   <= i_leader_cav_in;
                        r_state <= S_MULV;
                    end
                end
                S_MULV: begin
                    r_prod  <= n_mp;
                    r_state <= S_DIVA;
                end
                S_DIVA:  r_state <= S_DIVAW;
                S_DIVAW: begin
                    if (eng_done) begin
                        r_accq  <= eng_q[25:0];
                        r_state <= S_DIVT;
                    end
                end
                S_DIVT:  r_state <= S_DIVTW;
                S_DIVTW: begin
                    if (eng_done) begin
                        r_ttc_raw <= eng_q;
                        r_state   <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_sqx   <= n_mp;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_prod  <= n_mp;
                    r_state <= S_SQS;
                end
                S_SQS: begin
                    r_s     <= {1'b0, r_sqx} + {1'b0, r_prod};
                    r_state <= S_SQRT;
                end
                S_SQRT:  r_state <= S_SQRTW;
                S_SQRTW: begin
                    if (eng_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid     <= 1'b1;
                        r_out_acc       <= n_acc;
                        r_out_ttc       <= n_ttc_ok ? r_ttc_raw[17:0] : 18'd0;
                        r_out_ttc_ok    <= n_ttc_ok;
                        r_out_dist      <= n_in_ep ? n_dist : 32'd0;
                        r_out_hard      <= n_hard;
                        r_out_emer      <= n_emer;
                        r_out_coll      <= n_coll;
                        r_out_cav       <= r_gv && r_cav;
                        r_have_prev     <= 1'b1;
                        r_prev_spd      <= r_spd;
                        r_prev_t        <= r_t;
                        r_in_ep         <= n_in_ep;
                        r_dist          <= n_dist;
                        r_peak          <= n_peak;
                        r_hard_fired    <= n_hard_fired;
                        r_emer_fired    <= n_emer_fired;
                        r_stop_run      <= n_stop_run;
                        r_stopped_since <= n_ss;
                        if (n_in_ep) begin
                            r_last_x <= r_x;
                            r_last_y <= r_y;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_acceleration     = r_out_acc;
    assign o_ttc              = r_out_ttc;
    assign o_ttc_valid        = r_out_ttc_ok;
    assign o_braking_distance = r_out_dist;
    assign o_hard_brake       = r_out_hard;
    assign o_emergency_brake  = r_out_emer;
    assign o_collision        = r_out_coll;
    assign o_involves_cav     = r_out_cav;

`include "braking_episode_monitor_assert.svh"

    `BEM_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && o_in_ready, !o_in_ready)
    `BEM_ASSERT_SAME(a_done_only_waiting, eng_done, r_state == S_DIVAW || r_state == S_DIVTW || r_state == S_SQRTW)
    `BEM_ASSERT_SAME(a_coll_needs_stop, o_out_valid && o_collision, r_stop_run)

endmodule
